### sv/upload_session_tracker_assert.svh
// assertion macros for the upload session tracker checker
// depends on nothing; included by files that hold concurrent assertions
`ifndef UPLOAD_SESSION_TRACKER_ASSERT_SVH
`define UPLOAD_SESSION_TRACKER_ASSERT_SVH

// same-cycle implication, masked during reset
`define UST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("upload session tracker check failed");

// next-cycle implication, masked during reset
`define UST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("upload session tracker check failed");

// next-cycle implication that also holds across reset
`define UST_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("upload session tracker check failed");

`endif

### sv/ust_pkg.sv
// shared types and constants of the upload session tracker
// no dependencies; used by the decision logic, the top level and the checker
`default_nettype none

package ust_pkg;

   localparam int DEF_ID_BITS   = 64;
   localparam int DEF_SIZE_BITS = 32;

   localparam int ACTION_BITS   = 3;
   localparam int STATUS_BITS   = 3;
   localparam int PHASE_BITS    = 3;
   localparam int RSP_DATA_BITS = ((STATUS_BITS + PHASE_BITS + 7) / 8) * 8;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_PREPARE = 3'd0,
      ACT_RESERVE = 3'd1,
      ACT_BEGIN   = 3'd2,
      ACT_WRITE   = 3'd3,
      ACT_FINISH  = 3'd4,
      ACT_ABORT   = 3'd5
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK         = 3'd0,
      ST_INVALID    = 3'd1,
      ST_BUSY       = 3'd2,
      ST_REPLAY     = 3'd3,
      ST_ID_MISMATCH = 3'd4,
      ST_OFF_MISMATCH = 3'd5,
      ST_OVERFLOW   = 3'd6,
      ST_INCOMPLETE = 3'd7
   } status_type;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_IDLE    = 3'd0,
      PH_READY   = 3'd1,
      PH_WRITING = 3'd2,
      PH_PENDING = 3'd3,
      PH_FAILED  = 3'd4
   } phase_type;

   // session update controls from the decision logic to the datapath
   typedef struct packed {
      status_type status;
      phase_type  phase_next;
      logic       load_session;
      logic       clear_received;
      logic       add_received;
      logic       set_mark;
      logic       clear_mark;
   } decision_type;

endpackage

`default_nettype wire

### sv/ust_decide.sv
// per-request checks and phase transition of the upload session
// depends on ust_pkg; instantiated by upload_session_tracker
`default_nettype none

module ust_decide #(
   parameter int ID_BITS   = ust_pkg::DEF_ID_BITS,
   parameter int SIZE_BITS = ust_pkg::DEF_SIZE_BITS
) (
   input  wire logic [ust_pkg::ACTION_BITS-1:0] action,
   input  wire logic [ID_BITS-1:0]              session_id,
   input  wire logic                            id_present,
   input  wire logic [SIZE_BITS-1:0]            byte_count,
   input  wire logic [SIZE_BITS-1:0]            chunk_offset,
   input  wire logic                            grant_flag,
   input  wire ust_pkg::phase_type              phase,
   input  wire logic [ID_BITS-1:0]              held_id,
   input  wire logic [SIZE_BITS-1:0]            total_expected,
   input  wire logic [SIZE_BITS-1:0]            total_received,
   input  wire logic                            reserved_mark,
   output ust_pkg::decision_type                decision
);
   import ust_pkg::*;

   logic                 id_equal;
   logic                 id_same;
   logic [SIZE_BITS-1:0] room;
   status_type           gate;
   status_type           status;
   phase_type            phase_next;

   assign id_equal = (session_id == held_id);
   assign id_same  = id_present && id_equal;
   assign room     = (total_expected >= total_received) ?
                     (total_expected - total_received) : '0;

   // shared phase gate of reserve and begin
   always_comb begin
      unique case (phase)
         PH_READY:   gate = ST_OK;
         PH_WRITING: gate = ST_BUSY;
         PH_PENDING: gate = ST_REPLAY;
         default:    gate = ST_INVALID;
      endcase
   end

   // status
   always_comb begin
      status = ST_OK;
      unique case (action)
         ACT_PREPARE: begin
            if (!id_present || (byte_count == '0)) status = ST_INVALID;
            else if (phase == PH_WRITING)          status = ST_BUSY;
            else if (phase == PH_PENDING)          status = id_equal ? ST_REPLAY : ST_BUSY;
            else if ((phase == PH_READY) && id_equal) status = ST_REPLAY;
         end
         ACT_RESERVE: begin
            if (gate != ST_OK)  status = gate;
            else if (!id_same)  status = ST_ID_MISMATCH;
            else if (!grant_flag) status = ST_BUSY;
         end
         ACT_BEGIN: begin
            if (gate != ST_OK)     status = gate;
            else if (!id_same)     status = ST_ID_MISMATCH;
            else if (!reserved_mark) status = ST_BUSY;
         end
         ACT_WRITE: begin
            if (phase != PH_WRITING)              status = ST_INVALID;
            else if (!id_same)                    status = ST_ID_MISMATCH;
            else if (chunk_offset != total_received) status = ST_OFF_MISMATCH;
            else if (byte_count > room)           status = ST_OVERFLOW;
         end
         ACT_FINISH: begin
            if (phase != PH_WRITING)                 status = ST_INVALID;
            else if (!id_same)                       status = ST_ID_MISMATCH;
            else if (total_received != total_expected) status = ST_INCOMPLETE;
         end
         ACT_ABORT: status = ST_OK;
         default:   status = ST_INVALID;
      endcase
   end

   // next phase
   always_comb begin
      phase_next = phase;
      unique case (action)
         ACT_PREPARE: if (status == ST_OK) phase_next = PH_READY;
         ACT_BEGIN:   if (status == ST_OK) phase_next = PH_WRITING;
         ACT_FINISH:  if (status == ST_OK) phase_next = PH_PENDING;
         ACT_ABORT:   if (phase != PH_PENDING) phase_next = PH_FAILED;
         default:     phase_next = phase;
      endcase
   end

   // update controls
   always_comb begin
      logic ok;
      logic abort_hit;
      ok        = (status == ST_OK);
      abort_hit = (action == ACT_ABORT) && (phase != PH_PENDING);
      decision.status         = status;
      decision.phase_next     = phase_next;
      decision.load_session   = ok && (action == ACT_PREPARE);
      decision.clear_received = (ok && ((action == ACT_PREPARE) || (action == ACT_BEGIN)))
                                || abort_hit;
      decision.add_received   = ok && (action == ACT_WRITE);
      decision.set_mark       = ok && (action == ACT_RESERVE);
      decision.clear_mark     = (ok && (action == ACT_PREPARE)) || abort_hit;
   end

endmodule

`default_nettype wire

### sv/upload_session_tracker.sv
// top level of the upload session tracker: request register, session state,
// response register; depends on ust_pkg and ust_decide
`default_nettype none

// usage
//   requests enter on req_*: tuser carries the action code, tdata the identifier,
//   its present flag, the byte count, the chunk offset and the grant flag
//   every request yields exactly one response on rsp_*: status and the phase
//   after the request
//   a taken request goes through the request register, then the response register
//   throughput: one request per cycle while rsp_tready is high; the request
//   register feeds the decision logic, which updates the session state and loads
//   the response register in the same cycle, so the next request sees the new state
//   stall: while rsp_tready is low the response holds, the request register keeps
//   one more request, and req_tready drops once both are full
//   reset: synchronous, active high; empties both registers and returns the
//   session to idle with zero identifier, counts and reservation
module upload_session_tracker #(
   parameter int ID_BITS   = ust_pkg::DEF_ID_BITS,
   parameter int SIZE_BITS = ust_pkg::DEF_SIZE_BITS,
   localparam int REQ_DATA_BITS = ((ID_BITS + 2 * SIZE_BITS + 2 + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // session_id, id_present, byte_count, chunk_offset, grant_flag, zero fill
   input  wire logic [REQ_DATA_BITS-1:0]          req_tdata,
   // action
   input  wire logic [ust_pkg::ACTION_BITS-1:0]   req_tuser,
   // response channel
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status, phase_now, zero fill
   output      logic [ust_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import ust_pkg::*;

   // field positions inside req_tdata
   localparam int PRESENT_POS = ID_BITS;
   localparam int COUNT_LSB   = ID_BITS + 1;
   localparam int OFFSET_LSB  = COUNT_LSB + SIZE_BITS;
   localparam int GRANT_POS   = OFFSET_LSB + SIZE_BITS;
   localparam int RSP_FILL    = RSP_DATA_BITS - STATUS_BITS - PHASE_BITS;

   // request register
   logic                   req_valid_ff, req_valid_in;
   logic [ACTION_BITS-1:0] action_ff;
   logic [ID_BITS-1:0]     session_id_ff;
   logic                   id_present_ff;
   logic [SIZE_BITS-1:0]   byte_count_ff;
   logic [SIZE_BITS-1:0]   chunk_offset_ff;
   logic                   grant_flag_ff;

   // session state
   phase_type              phase_ff, phase_in;
   logic [ID_BITS-1:0]     held_id_ff, held_id_in;
   logic [SIZE_BITS-1:0]   expected_ff, expected_in;
   logic [SIZE_BITS-1:0]   received_ff, received_in;
   logic                   mark_ff, mark_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff;
   phase_type              rsp_phase_ff;

   logic                   req_take;
   logic                   advance;
   decision_type           decision;

   // the request register moves on whenever the response slot is free or freeing
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_FILL{1'b0}}, rsp_phase_ff, rsp_status_ff};

   ust_decide #(
      .ID_BITS  (ID_BITS),
      .SIZE_BITS(SIZE_BITS)
   ) u_decide (
      .action        (action_ff),
      .session_id    (session_id_ff),
      .id_present    (id_present_ff),
      .byte_count    (byte_count_ff),
      .chunk_offset  (chunk_offset_ff),
      .grant_flag    (grant_flag_ff),
      .phase         (phase_ff),
      .held_id       (held_id_ff),
      .total_expected(expected_ff),
      .total_received(received_ff),
      .reserved_mark (mark_ff),
      .decision      (decision)
   );

   // handshake flags
   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take)     req_valid_in = 1'b1;
      else if (advance) req_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance)         rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // session state update, applied only when a request completes
   always_comb begin
      phase_in    = phase_ff;
      held_id_in  = held_id_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      mark_in     = mark_ff;
      if (advance) begin
         phase_in = decision.phase_next;
         if (decision.load_session) begin
            held_id_in  = session_id_ff;
            expected_in = byte_count_ff;
         end
         if (decision.clear_received)    received_in = '0;
         else if (decision.add_received) received_in = received_ff + byte_count_ff;
         if (decision.clear_mark)        mark_in = 1'b0;
         else if (decision.set_mark)     mark_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         held_id_ff   <= '0;
         expected_ff  <= '0;
         received_ff  <= '0;
         mark_ff      <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         held_id_ff   <= held_id_in;
         expected_ff  <= expected_in;
         received_ff  <= received_in;
         mark_ff      <= mark_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff       <= req_tuser;
         session_id_ff   <= req_tdata[0 +: ID_BITS];
         id_present_ff   <= req_tdata[PRESENT_POS];
         byte_count_ff   <= req_tdata[COUNT_LSB +: SIZE_BITS];
         chunk_offset_ff <= req_tdata[OFFSET_LSB +: SIZE_BITS];
         grant_flag_ff   <= req_tdata[GRANT_POS];
      end
      if (advance) begin
         rsp_status_ff <= decision.status;
         rsp_phase_ff  <= decision.phase_next;
      end
   end

endmodule

`default_nettype wire

### sv/ust_checker.sv
// port-level checks of the upload session tracker response channel
// depends on ust_pkg and upload_session_tracker_assert.svh; bound to the top level
`default_nettype none

`include "upload_session_tracker_assert.svh"

module ust_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [ust_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import ust_pkg::*;

   logic [STATUS_BITS-1:0] status;
   logic [PHASE_BITS-1:0]  phase_now;
   logic                   stalled;

   assign status    = rsp_tdata[0 +: STATUS_BITS];
   assign phase_now = rsp_tdata[STATUS_BITS +: PHASE_BITS];
   assign stalled   = rsp_tvalid && !rsp_tready;

   // reset leaves no response pending
   `UST_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)

   // a stalled response holds
   `UST_ASSERT_NEXT(a_stall_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata))

   // chunk and completeness errors only arise while writing, which they keep
   `UST_ASSERT_NOW(a_write_errors, clock, reset,
      rsp_tvalid && ((status == ST_OFF_MISMATCH) || (status == ST_OVERFLOW) ||
                     (status == ST_INCOMPLETE)),
      phase_now == PH_WRITING)

   // replay is only reported with a live session
   `UST_ASSERT_NOW(a_replay_phase, clock, reset,
      rsp_tvalid && (status == ST_REPLAY),
      (phase_now == PH_READY) || (phase_now == PH_PENDING))

endmodule

bind upload_session_tracker ust_checker u_ust_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire
